[src/v3n_pkg.sv]
// Shared widths and helper functions for the 3D vector normalizer.
package v3n_pkg;
    localparam int CompWidth = 24;
    localparam int FracBits  = 16;
    localparam int SumWidth  = 2 * CompWidth;
    localparam int WideWidth = SumWidth + 2 * FracBits + 3;
    localparam int OutWidth  = FracBits + 2;
    localparam int QWidth    = FracBits + 1;
    localparam int NumStages = FracBits + 4;

    typedef logic [CompWidth-1:0] t_mag;
    typedef logic [SumWidth-1:0]  t_sum;
    typedef logic [WideWidth-1:0] t_wide;
    typedef logic [QWidth-1:0]    t_q;
    typedef logic signed [OutWidth-1:0] t_unit;

    // Magnitude of a two's complement component; the most negative value maps exactly.
    function automatic t_mag mag_of(input logic [CompWidth-1:0] c);
        mag_of = c[CompWidth-1] ? t_mag'(~c + 1'b1) : c;
    endfunction

    // Apply the component's sign to an unsigned unit magnitude.
    function automatic t_unit signed_unit(input t_q q, input logic neg);
        logic [OutWidth-1:0] ext;
        ext = {1'b0, q};
        signed_unit = neg ? t_unit'(~ext + 1'b1) : t_unit'(ext);
    endfunction
endpackage

[src/vector3_normalize_top.sv]
// Top level of the pipelined 3D vector normalizer.
//
//  channel | valid   | stall    | word
//  --------+---------+----------+----------------------------------------------
//  input   | i_valid | o_stall  | i_comp_x, i_comp_y, i_comp_z
//  output  | o_valid | i_stall  | o_unit_x, o_unit_y, o_unit_z, o_zero_length
//
// One word enters per cycle while the pipeline is not stalled.
// The pipeline has one magnitude and square stage, one sum stage, one stage per
// result bit of a restoring square root style search, and an output stage.
// Each stage holds its word unless the next stage is free or moving, so
// bubbles collapse and a stall at the output backs up stage by stage.
// Reset (synchronous, active low) clears only the valid bits.
//
// The bit search keeps, per component, the remainder R = c^2 * 2^(2F) - q^2 * S
// and the product P = q * S. Trying bit b costs D = 2^(b+1) * P + 2^(2b) * S,
// which needs shifts and adds only; the bit is kept when D does not exceed R.
module vector3_normalize_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [v3n_pkg::CompWidth-1:0]       i_comp_x,
    input  logic [v3n_pkg::CompWidth-1:0]       i_comp_y,
    input  logic [v3n_pkg::CompWidth-1:0]       i_comp_z,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [v3n_pkg::OutWidth-1:0] o_unit_x,
    output logic signed [v3n_pkg::OutWidth-1:0] o_unit_y,
    output logic signed [v3n_pkg::OutWidth-1:0] o_unit_z,
    output logic                                o_zero_length
);
    localparam int F  = v3n_pkg::FracBits;
    localparam int NS = v3n_pkg::NumStages;

    // Stage 0 is squares, stages 1 .. F+2 carry the search, stage NS-1 is output.
    logic [NS-1:0] r_v;
    logic [NS:0]   adv;

    always_comb begin
        adv[NS] = ~i_stall;
        for (int k = NS - 1; k >= 0; k--) begin
            adv[k] = ~r_v[k] | adv[k+1];
        end
    end

    assign o_stall = ~adv[0];
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 0: signs and squares of the magnitudes.
    logic [v3n_pkg::CompWidth-1:0] comp_in [0:2];
    logic [2:0]                    r_a_neg;
    v3n_pkg::t_sum                 r_a_sq [0:2];

    assign comp_in[0] = i_comp_x;
    assign comp_in[1] = i_comp_y;
    assign comp_in[2] = i_comp_z;

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            for (int i = 0; i < 3; i++) begin
                r_a_neg[i] <= comp_in[i][v3n_pkg::CompWidth-1];
                r_a_sq[i]  <= v3n_pkg::t_sum'(v3n_pkg::mag_of(comp_in[i]))
                            * v3n_pkg::t_sum'(v3n_pkg::mag_of(comp_in[i]));
            end
        end
    end

    // Search stages: index j holds the state before bit F-j is tried.
    v3n_pkg::t_wide r_rem [0:F+1][0:2];
    v3n_pkg::t_wide r_p   [0:F+1][0:2];
    v3n_pkg::t_q    r_q   [0:F+1][0:2];
    v3n_pkg::t_sum  r_s   [0:F+1];
    logic [2:0]     r_neg [0:F+1];
    logic           r_zero [0:F+1];

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_s[0]    <= r_a_sq[0] + r_a_sq[1] + r_a_sq[2];
            r_zero[0] <= (r_a_sq[0] == '0) && (r_a_sq[1] == '0) && (r_a_sq[2] == '0);
            r_neg[0]  <= r_a_neg;
            for (int i = 0; i < 3; i++) begin
                r_rem[0][i] <= v3n_pkg::t_wide'(r_a_sq[i]) << (2 * F);
                r_p[0][i]   <= '0;
                r_q[0][i]   <= '0;
            end
        end
    end

    for (genvar j = 0; j <= F; j++) begin : g_bit
        localparam int B = F - j;
        v3n_pkg::t_wide s_w;
        v3n_pkg::t_wide cost [0:2];

        assign s_w = v3n_pkg::t_wide'(r_s[j]);

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                cost[i] = (r_p[j][i] << (B + 1)) + (s_w << (2 * B));
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv[j+2]) begin
                r_s[j+1]    <= r_s[j];
                r_zero[j+1] <= r_zero[j];
                r_neg[j+1]  <= r_neg[j];
                for (int i = 0; i < 3; i++) begin
                    if (cost[i] <= r_rem[j][i]) begin
                        r_rem[j+1][i] <= r_rem[j][i] - cost[i];
                        r_p[j+1][i]   <= r_p[j][i] + (s_w << B);
                        r_q[j+1][i]   <= r_q[j][i] | (v3n_pkg::t_q'(1) << B);
                    end else begin
                        r_rem[j+1][i] <= r_rem[j][i];
                        r_p[j+1][i]   <= r_p[j][i];
                        r_q[j+1][i]   <= r_q[j][i];
                    end
                end
            end
        end
    end

    // Output stage: restore signs; the zero vector forces zero units.
    always_ff @(posedge i_clk) begin
        if (adv[NS-1]) begin
            o_zero_length <= r_zero[F+1];
            if (r_zero[F+1]) begin
                o_unit_x <= '0;
                o_unit_y <= '0;
                o_unit_z <= '0;
            end else begin
                o_unit_x <= v3n_pkg::signed_unit(r_q[F+1][0], r_neg[F+1][0]);
                o_unit_y <= v3n_pkg::signed_unit(r_q[F+1][1], r_neg[F+1][1]);
                o_unit_z <= v3n_pkg::signed_unit(r_q[F+1][2], r_neg[F+1][2]);
            end
        end
    end

    // A zero-length result carries zero units.
    a_zero_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_length |-> o_unit_x == '0 && o_unit_y == '0 && o_unit_z == '0)
        else $error("zero-length word has nonzero unit components");

    // No unit component exceeds one in magnitude.
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_unit_x <= (1 <<< F) && o_unit_x >= -(1 <<< F)
                 && o_unit_y <= (1 <<< F) && o_unit_y >= -(1 <<< F)
                 && o_unit_z <= (1 <<< F) && o_unit_z >= -(1 <<< F))
        else $error("unit component out of range");

    // The input side only stalls when every stage is full.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_v == '1 && i_stall)
        else $error("input stalled while the pipeline has a free stage");
endmodule

[tb/tb_vector3_normalize_top.sv]
// Self-checking testbench for the pipelined 3D vector normalizer.
`timescale 1ns / 100ps

module tb_vector3_normalize_top;
    localparam int CompWidth = v3n_pkg::CompWidth;
    localparam int FracBits  = v3n_pkg::FracBits;
    localparam int SumWidth  = v3n_pkg::SumWidth;
    localparam int OutWidth  = v3n_pkg::OutWidth;
    localparam int QWidth    = v3n_pkg::QWidth;
    localparam int Latency   = v3n_pkg::NumStages;

    // One expected result word.
    typedef struct {
        logic signed [OutWidth-1:0] ux;
        logic signed [OutWidth-1:0] uy;
        logic signed [OutWidth-1:0] uz;
        logic                       zl;
    } t_unit_word;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [CompWidth-1:0]   i_comp_x = '0;
    logic [CompWidth-1:0]   i_comp_y = '0;
    logic [CompWidth-1:0]   i_comp_z = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic signed [OutWidth-1:0] o_unit_x, o_unit_y, o_unit_z;
    logic                   o_zero_length;

    t_unit_word expected_units[$];
    int  error_count = 0;
    bit  hold_output = 1'b0;
    int  burst_left = 0;

    vector3_normalize_top DUT (.*);

    always #5 i_clk = ~i_clk;

    // Largest q with q*q*sum <= mag*mag*2^(2F), found one bit at a time.
    function automatic logic [QWidth-1:0] unit_mag(input logic [CompWidth-1:0] mag,
                                                   input logic [SumWidth+1:0] sum);
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [QWidth-1:0] q;
        logic [QWidth-1:0] t;
        rhs = (128'(mag) * 128'(mag)) << (2 * FracBits);
        q = '0;
        for (int b = FracBits; b >= 0; b--) begin
            t = q | (QWidth'(1) << b);
            lhs = 128'(t) * 128'(t) * 128'(sum);
            if (lhs <= rhs) q = t;
        end
        return q;
    endfunction

    function automatic t_unit_word normalize(input logic [CompWidth-1:0] cx,
                                             input logic [CompWidth-1:0] cy,
                                             input logic [CompWidth-1:0] cz);
        logic [CompWidth-1:0] c [3];
        logic [CompWidth-1:0] m [3];
        logic signed [OutWidth-1:0] u [3];
        logic [SumWidth+1:0] sum;
        t_unit_word w;
        c[0] = cx; c[1] = cy; c[2] = cz;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            m[i] = c[i][CompWidth-1] ? CompWidth'(-c[i]) : c[i];
            sum += (SumWidth+2)'(m[i]) * (SumWidth+2)'(m[i]);
        end
        for (int i = 0; i < 3; i++) begin
            u[i] = (sum == 0) ? '0 : OutWidth'(unit_mag(m[i], sum));
            if (c[i][CompWidth-1]) u[i] = -u[i];
        end
        w.ux = u[0]; w.uy = u[1]; w.uz = u[2]; w.zl = (sum == 0);
        return w;
    endfunction

    // Sends one word; it waits in bursts with random gaps and holds while stalled.
    task automatic send_vector(input logic [CompWidth-1:0] cx,
                               input logic [CompWidth-1:0] cy,
                               input logic [CompWidth-1:0] cz);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 2) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid  <= 1'b1;
        i_comp_x <= cx;
        i_comp_y <= cy;
        i_comp_z <= cz;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // The word was taken at this edge.
        expected_units.push_back(normalize(cx, cy, cz));
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
    endtask

    function automatic logic [CompWidth-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return {1'b1, {(CompWidth-1){1'b0}}};
            2:       return {1'b0, {(CompWidth-1){1'b1}}};
            3:       return CompWidth'($urandom_range(0, 15)) - CompWidth'(8);
            default: return CompWidth'($urandom);
        endcase
    endfunction

    // Extremes, the zero vector, single-axis vectors and sign mixes.
    task automatic test_directed();
        logic [CompWidth-1:0] mx, mn, zr, p1, m1;
        mx = {1'b0, {(CompWidth-1){1'b1}}};
        mn = {1'b1, {(CompWidth-1){1'b0}}};
        zr = '0;
        p1 = CompWidth'(1);
        m1 = '1;
        send_vector(zr, zr, zr);
        send_vector(p1, zr, zr);
        send_vector(zr, m1, zr);
        send_vector(zr, zr, mn);
        send_vector(mx, zr, zr);
        send_vector(mn, mn, mn);
        send_vector(mx, mx, mx);
        send_vector(mn, mx, zr);
        send_vector(p1, p1, p1);
        send_vector(m1, p1, m1);
        send_vector(CompWidth'(3), CompWidth'(4), zr);
        send_vector(mx, p1, m1);
        send_vector(p1, mn, zr);
        send_vector(-CompWidth'(2), CompWidth'(3), -CompWidth'(6));
        send_vector(zr, zr, zr);
        go_idle();
    endtask

    // Random vectors, with small and full-scale values mixed.
    task automatic test_random(input int count);
        for (int n = 0; n < count; n++)
            send_vector(rand_comp(), rand_comp(), rand_comp());
        go_idle();
    endtask

    // The receiver holds off long enough for the pipeline to back up fully.
    task automatic test_backpressure();
        hold_output = 1'b1;
        for (int n = 0; n < 3 * Latency; n++)
            send_vector(rand_comp(), rand_comp(), rand_comp());
        go_idle();
        hold_output = 1'b0;
    endtask

    // The sender pauses until every result has come back.
    task automatic drain_results();
        while (expected_units.size() != 0) @(posedge i_clk);
    endtask

    // Output stall pattern: runs of free flow, random stalls, and long counted holds.
    initial begin
        int hold_cycles;
        forever begin
            @(posedge i_clk);
            if (hold_output) begin
                i_stall <= 1'b1;
                hold_cycles = 0;
                while (hold_cycles < 4 * Latency) begin
                    @(posedge i_clk);
                    hold_cycles++;
                end
                i_stall <= 1'b0;
            end else if ($urandom_range(0, 99) < 40) begin
                i_stall <= ($urandom_range(0, 2) == 0);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Compare each accepted result word with the oldest expectation.
    always @(posedge i_clk) begin
        t_unit_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_units.size() == 0) begin
                $display("%0t: unexpected word ux=%0d uy=%0d uz=%0d zl=%0b", $time,
                         o_unit_x, o_unit_y, o_unit_z, o_zero_length);
                error_count++;
            end else begin
                want = expected_units.pop_front();
                if (o_unit_x !== want.ux || o_unit_y !== want.uy ||
                    o_unit_z !== want.uz || o_zero_length !== want.zl) begin
                    $display("%0t: expected %0d %0d %0d %0b actual %0d %0d %0d %0b",
                             $time, want.ux, want.uy, want.uz, want.zl,
                             o_unit_x, o_unit_y, o_unit_z, o_zero_length);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        drain_results();
        test_backpressure();
        drain_results();
        test_random(1750);
        drain_results();
        repeat (Latency + 5) @(posedge i_clk);
        if (error_count == 0)
            $display("vector3_normalize_top regression: pass");
        else
            $display("vector3_normalize_top regression: fail");
        $finish;
    end

    initial begin
        #5ms;
        $display("vector3_normalize_top regression: fail");
        $finish;
    end
endmodule
